>>> design/sis_pkg.sv
// Package for the sorted integer set: field widths, request and status codes,
// and the command word from the controller to the datapath. No dependencies.
package sis_pkg;

   // Field widths of the request and response words
   localparam int MODE_W      = 2;
   localparam int KEY_W       = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_MEMBER = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_NO   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_YES  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request word and the per-cell compares
      logic apply;     // update the cells and the count, form the response
   } cmd_type;

endpackage

>>> design/sis_ctrl.sv
// Controller for the sorted integer set: two-state sequencer that accepts a
// request word, runs the update step and strobes the response. Uses sis_pkg.
module sis_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output sis_pkg::cmd_type cmd
);
   import sis_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_APPLY = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Decode commands from the current state
   always_comb begin
      busy        = (state_ff == ST_APPLY);
      cmd.capture = start && !busy;
      cmd.apply   = (state_ff == ST_APPLY);
   end

   // Next state: the update state follows each accepted word
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.apply;
   end

   // Hold state and the response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/sis_datapath.sv
// Datapath for the sorted integer set: a row of compare-and-shift cells, the
// entry count and the response registers. Uses sis_pkg commands and codes.
module sis_datapath #(
   parameter int CAPACITY = 64,
   parameter int COUNT_W  = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sis_pkg::cmd_type                    cmd,
   input  logic [sis_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [sis_pkg::KEY_W-1:0]    req_key_value,
   output logic [sis_pkg::STATUS_W-1:0]        rsp_status,
   output logic [sis_pkg::COUNT_OUT_W-1:0]     rsp_entry_count
);
   import sis_pkg::*;

   // Cell contents, ascending; only the first count_ff cells are meaningful
   logic signed [KEY_W-1:0] value_ff [CAPACITY];
   logic signed [KEY_W-1:0] value_in [CAPACITY];

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [MODE_W-1:0]   mode_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [CAPACITY-1:0] less_ff, less_in;
   logic [CAPACITY-1:0] equal_ff, equal_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [COUNT_OUT_W-1:0] count_out_ff;
   logic [COUNT_W+COUNT_OUT_W-1:0] count_ext;

   logic hit;
   logic full;
   logic ins_en;
   logic del_en;

   // Compare the incoming key against every held cell
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         less_in[i]  = (COUNT_W'(i) < count_ff) && (value_ff[i] < req_key_value);
         equal_in[i] = (COUNT_W'(i) < count_ff) && (value_ff[i] == req_key_value);
      end
   end

   // Latch the request word and the compare results
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key_value;
         less_ff  <= less_in;
         equal_ff <= equal_in;
      end
   end

   // Decide the operation
   always_comb begin
      hit    = |equal_ff;
      full   = (count_ff >= COUNT_W'(CAPACITY));
      ins_en = (mode_ff == MODE_INSERT) && !hit && !full;
      del_en = (mode_ff == MODE_DELETE) && hit;
   end

   // Per-cell next value: shift up from the insert point, down from the hit
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [KEY_W-1:0] lower_val;
      logic signed [KEY_W-1:0] upper_val;
      logic                    lower_less;

      if (g == 0) begin : g_first
         assign lower_val  = key_ff;
         assign lower_less = 1'b1;
      end else begin : g_inner
         assign lower_val  = value_ff[g-1];
         assign lower_less = less_ff[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign upper_val = value_ff[g];
      end else begin : g_below
         assign upper_val = value_ff[g+1];
      end

      always_comb begin
         value_in[g] = value_ff[g];
         if (ins_en && !less_ff[g]) begin
            value_in[g] = lower_less ? key_ff : lower_val;
         end else if (del_en && !less_ff[g]) begin
            value_in[g] = upper_val;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.apply) value_ff[g] <= value_in[g];
      end
   end

   // Next count and response status
   always_comb begin
      count_in = count_ff;
      if (ins_en) count_in = count_ff + COUNT_W'(1);
      else if (del_en) count_in = count_ff - COUNT_W'(1);

      case (mode_ff)
         MODE_MEMBER: status_in = hit ? STATUS_YES : STATUS_NO;
         MODE_INSERT: status_in = hit ? STATUS_NO : (full ? STATUS_FULL : STATUS_YES);
         MODE_DELETE: status_in = hit ? STATUS_YES : STATUS_NO;
         default:     status_in = STATUS_NO;
      endcase

      count_ext = {{COUNT_OUT_W{1'b0}}, count_in};
   end

   // Hold the entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
      end
   end

   // Hold the response word
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         status_ff    <= status_in;
         count_out_ff <= count_ext[COUNT_OUT_W-1:0];
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_out_ff;

endmodule

>>> design/sorted_integer_set_top.sv
// Top level of the sorted integer set: joins the controller and the cell
// datapath. Depends on sis_pkg, sis_ctrl and sis_datapath.
//
// Usage:
//   Request channel: drive req_mode and req_key_value with start high; the
//   word is taken at a rising edge where start is high and busy is low.
//   Modes: 0 membership query, 1 insert, 2 delete; 3 changes nothing.
//   Response channel: rsp_valid is high for exactly one cycle, once the
//   update state has loaded the response, carrying rsp_status (0 no, 1 yes, 2 insert
//   rejected because full) and rsp_entry_count (count after the request,
//   modulo 128). The receiver cannot stall; the response must be taken.
//   A new word is not taken while busy. All cells compare the key in
//   parallel as the word is accepted; the following cycle ORs the equal
//   flags and shifts the cell row by one place for an insert or delete.
//   busy is high during that update cycle only; a new word may be accepted
//   in the same cycle as rsp_valid.
//   Reset: synchronous, active high; it empties the set (count zero). Cell
//   contents are not cleared, as only cells below the count are read.
module sorted_integer_set_top #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [sis_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [sis_pkg::KEY_W-1:0]    req_key_value,
   output logic                                rsp_valid,
   output logic [sis_pkg::STATUS_W-1:0]        rsp_status,
   output logic [sis_pkg::COUNT_OUT_W-1:0]     rsp_entry_count
);
   import sis_pkg::*;

   localparam int COUNT_W = $clog2(CAPACITY + 1);

   cmd_type cmd;

   // Sequence the request
   sis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Compare and shift the cells
   sis_datapath #(
      .CAPACITY (CAPACITY),
      .COUNT_W  (COUNT_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_mode),
      .req_key_value   (req_key_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
